// ===== hw/rtl/tpm_pkg.sv =====
// Shared types, constants and the seven-point evaluation function for the
// Toom-4 polynomial multiplier. No dependencies.
package tpm_pkg;

  localparam int unsigned CoeffCount = 16;
  localparam int unsigned IdxW       = $clog2(CoeffCount);

  typedef logic [31:0]      word_t;
  typedef word_t [6:0]      pts_t;
  typedef logic [32:0]      wide_t;
  typedef logic [26:0]      coef_t;
  typedef logic [IdxW-1:0]  idx_t;

  localparam wide_t Mask33 = 33'h1_FFFF_FFFF;
  localparam wide_t Mask31 = 33'h0_7FFF_FFFF;
  localparam wide_t Mask30 = 33'h0_3FFF_FFFF;
  localparam wide_t Mask28 = 33'h0_0FFF_FFFF;
  localparam wide_t Mask27 = 33'h0_07FF_FFFF;

  localparam word_t KInv3   = 32'h2AAA_AAAB;
  localparam word_t KInv15I = 32'h6EEE_EEEF;
  localparam word_t KInv9I  = 32'h38E3_8E39;
  localparam word_t KInv15O = 32'h0EEE_EEEF;
  localparam word_t KInv9O  = 32'h08E3_8E39;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_LOAD,
    DP_OEVAL,
    DP_IEVAL,
    DP_IMUL,
    DP_S_A,
    DP_S_B,
    DP_S_C,
    DP_S_D,
    DP_S_E,
    DP_S_M4,
    DP_S_M5,
    DP_S_M1,
    DP_S_F,
    DP_S_G,
    DP_OLOAD,
    DP_FIX,
    DP_SHIFT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OEVAL,
    ST_IEVAL,
    ST_IMUL,
    ST_ISTEP,
    ST_OLOAD,
    ST_OSTEP,
    ST_FIX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   outer;
    idx_t   load_idx;
  } cmd_t;

  localparam logic [3:0] LastStep = 4'd9;

  function automatic dp_op_e step_op(logic [3:0] step);
    dp_op_e op;
    unique case (step)
      4'd0:    op = DP_S_A;
      4'd1:    op = DP_S_B;
      4'd2:    op = DP_S_C;
      4'd3:    op = DP_S_D;
      4'd4:    op = DP_S_E;
      4'd5:    op = DP_S_M4;
      4'd6:    op = DP_S_M5;
      4'd7:    op = DP_S_M1;
      4'd8:    op = DP_S_F;
      4'd9:    op = DP_S_G;
      default: op = DP_IDLE;
    endcase
    return op;
  endfunction

  // Values at the points inf, 2, +1, -1, +1/2, -1/2 (scaled) and 0, wrapping at 32 bits.
  function automatic pts_t eval4(word_t x0, word_t x1, word_t x2, word_t x3);
    pts_t  p;
    word_t s;
    word_t t;
    s    = x0 + x2;
    t    = x1 + x3;
    p[2] = s + t;
    p[3] = s - t;
    s    = ((x0 << 2) + x2) << 1;
    t    = (x1 << 2) + x3;
    p[4] = s + t;
    p[5] = s - t;
    p[1] = (x3 << 3) + (x2 << 2) + (x1 << 1) + x0;
    p[6] = x0;
    p[0] = x3;
    return p;
  endfunction

endpackage

// ===== hw/rtl/tpm_datapath.sv =====
// Datapath: coefficient stores, evaluation, one shared multiplier, the
// interpolation step unit and the result buffer. Depends on tpm_pkg.
module tpm_datapath (
  input  logic          clk_i,
  input  tpm_pkg::cmd_t cmd_i,
  input  logic [31:0]   coeff_a_i,
  input  logic [31:0]   coeff_b_i,
  output logic [26:0]   product_coeff_o
);
  import tpm_pkg::*;

  word_t       store_a_q [CoeffCount];
  word_t       store_b_q [CoeffCount];
  word_t       pa_q      [7][4];
  word_t       pb_q      [7][4];
  pts_t        ea_q, eb_q;
  wide_t       w_q       [7];
  logic [29:0] res_q     [7][4];
  wide_t       r1_q, r2_q, r3_q, r4_q, r5_q;
  coef_t       cbuf_q    [CoeffCount];
  coef_t       p0_q, p1_q, p2_q;

  wide_t       m_early, m_mul, m_fin;
  word_t       mul_a, mul_b;
  logic [63:0] prod;
  wide_t       prod_lo;
  logic [33:0] sum5;
  wide_t       s1, d3, df, r1n;
  pts_t        pts_a [4];
  pts_t        pts_b [4];
  pts_t        iev_a, iev_b;

  assign m_early = cmd_i.outer ? Mask30 : Mask33;
  assign m_mul   = cmd_i.outer ? Mask28 : Mask31;
  assign m_fin   = cmd_i.outer ? Mask27 : Mask30;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      pts_a[j] = eval4(store_a_q[4*j], store_a_q[4*j+1], store_a_q[4*j+2], store_a_q[4*j+3]);
      pts_b[j] = eval4(store_b_q[4*j], store_b_q[4*j+1], store_b_q[4*j+2], store_b_q[4*j+3]);
    end
    iev_a = eval4(pa_q[0][0], pa_q[0][1], pa_q[0][2], pa_q[0][3]);
    iev_b = eval4(pb_q[0][0], pb_q[0][1], pb_q[0][2], pb_q[0][3]);
  end

  // shared multiplier operand selection
  always_comb begin
    sum5 = {1'b0, r5_q} + {1'b0, r1_q};
    s1   = (r1_q + (r3_q << 4)) & m_early;
    unique case (cmd_i.op)
      DP_S_M4: begin
        mul_a = {2'b00, r4_q[29:0]};
        mul_b = KInv3;
      end
      DP_S_M5: begin
        mul_a = {1'b0, sum5[31:1]};
        mul_b = cmd_i.outer ? KInv15O : KInv15I;
      end
      DP_S_M1: begin
        mul_a = {1'b0, s1[31:1]};
        mul_b = cmd_i.outer ? KInv9O : KInv9I;
      end
      default: begin
        mul_a = ea_q[0];
        mul_b = {{11{eb_q[0][20]}}, eb_q[0][20:0]};
      end
    endcase
    prod    = 64'(mul_a) * 64'(mul_b);
    prod_lo = prod[32:0];
    d3      = w_q[3] - w_q[2];
    df      = r1_q - r5_q;
    r1n     = r1_q - r5_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_IDLE: begin
      end
      DP_LOAD: begin
        store_a_q[cmd_i.load_idx] <= coeff_a_i;
        store_b_q[cmd_i.load_idx] <= coeff_b_i;
      end
      DP_OEVAL: begin
        for (int j = 0; j < 4; j++) begin
          for (int k = 0; k < 7; k++) begin
            pa_q[k][j] <= pts_a[j][k];
            pb_q[k][j] <= pts_b[j][k];
          end
        end
        p0_q <= '0;
        p1_q <= '0;
        p2_q <= '0;
      end
      DP_IEVAL: begin
        ea_q <= iev_a;
        eb_q <= iev_b;
        for (int k = 0; k < 6; k++) begin
          pa_q[k] <= pa_q[k+1];
          pb_q[k] <= pb_q[k+1];
        end
      end
      DP_IMUL: begin
        ea_q <= ea_q >> 32;
        eb_q <= eb_q >> 32;
        for (int k = 0; k < 6; k++) w_q[k] <= w_q[k+1];
        w_q[6] <= prod_lo;
      end
      DP_S_A: begin
        r5_q <= (w_q[5] - w_q[4]) & m_early;
        r3_q <= {1'b0, d3[32:1]} & m_early;
        r4_q <= (w_q[4] - w_q[0]) & m_early;
      end
      DP_S_B: begin
        r4_q <= ((r4_q << 1) + r5_q - (w_q[6] << 7)) & m_early;
        r2_q <= (w_q[2] + r3_q) & m_early;
      end
      DP_S_C: begin
        r1_q <= (w_q[1] + w_q[4] - (r2_q << 6) - r2_q) & m_early;
      end
      DP_S_D: begin
        r2_q <= (r2_q - w_q[6] - w_q[0]) & m_early;
      end
      DP_S_E: begin
        r1_q <= (r1_q + r2_q + (r2_q << 2) + (r2_q << 3) + (r2_q << 5)) & m_early;
        r4_q <= ((r4_q - (r2_q << 3)) & m_early) >> 3;
      end
      DP_S_M4: r4_q <= prod_lo & Mask30;
      DP_S_M5: r5_q <= prod_lo & m_mul;
      DP_S_M1: r1_q <= prod_lo & m_mul;
      DP_S_F: begin
        r2_q <= (r2_q - r4_q) & m_fin;
        r3_q <= (33'd0 - r3_q - r1_q) & m_fin;
        r5_q <= {1'b0, df[32:1]};
      end
      DP_S_G: begin
        r1_q <= r1n;
        if (cmd_i.outer) begin
          // fold in the overlap from the previous block
          for (int i = 0; i < CoeffCount - 4; i++) cbuf_q[i] <= cbuf_q[i+4];
          cbuf_q[CoeffCount-4] <= w_q[6][26:0] + p2_q;
          cbuf_q[CoeffCount-3] <= r5_q[26:0] + p1_q;
          cbuf_q[CoeffCount-2] <= r4_q[26:0] + p0_q;
          cbuf_q[CoeffCount-1] <= r3_q[26:0];
          p0_q <= w_q[0][26:0];
          p1_q <= r1n[26:0];
          p2_q <= r2_q[26:0];
        end else begin
          for (int k = 0; k < 6; k++) res_q[k] <= res_q[k+1];
          res_q[6][0] <= 30'(w_q[6] - r2_q);
          res_q[6][1] <= 30'(r5_q - r1n);
          res_q[6][2] <= 30'(r4_q - w_q[0]);
          res_q[6][3] <= r3_q[29:0];
        end
      end
      DP_OLOAD: begin
        for (int k = 0; k < 7; k++) begin
          w_q[k] <= {3'b000, res_q[k][0]};
          for (int j = 0; j < 3; j++) res_q[k][j] <= res_q[k][j+1];
        end
      end
      DP_FIX: begin
        // top three terms wrap back negatively
        cbuf_q[0] <= cbuf_q[0] - p2_q;
        cbuf_q[1] <= cbuf_q[1] - p1_q;
        cbuf_q[2] <= cbuf_q[2] - p0_q;
      end
      DP_SHIFT: begin
        for (int i = 0; i < CoeffCount - 1; i++) cbuf_q[i] <= cbuf_q[i+1];
      end
      default: begin
      end
    endcase
  end

  assign product_coeff_o = cbuf_q[0];

endmodule

// ===== hw/rtl/tpm_controller.sv =====
// Sequencer for loading, inner and outer Toom-4 passes and result output.
// Depends on tpm_pkg; drives tpm_datapath through cmd_t.
module tpm_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          last_coeff_o,
  output tpm_pkg::cmd_t cmd_o
);
  import tpm_pkg::*;

  state_e     state_q, state_d;
  idx_t       cnt_q, cnt_d;
  logic [3:0] step_q, step_d;
  logic [2:0] blk_q, blk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      step_q  <= '0;
      blk_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      blk_q   <= blk_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    blk_d   = blk_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == idx_t'(CoeffCount - 1)) state_d = ST_OEVAL;
        end
      end
      ST_OEVAL: begin
        blk_d   = '0;
        state_d = ST_IEVAL;
      end
      ST_IEVAL: begin
        cnt_d   = '0;
        state_d = ST_IMUL;
      end
      ST_IMUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == idx_t'(6)) begin
          step_d  = '0;
          state_d = ST_ISTEP;
        end
      end
      ST_ISTEP: begin
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          if (blk_q == 3'd6) begin
            blk_d   = '0;
            state_d = ST_OLOAD;
          end else begin
            blk_d   = blk_q + 1'b1;
            state_d = ST_IEVAL;
          end
        end
      end
      ST_OLOAD: begin
        step_d  = '0;
        state_d = ST_OSTEP;
      end
      ST_OSTEP: begin
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          if (blk_q == 3'd3) begin
            state_d = ST_FIX;
          end else begin
            blk_d   = blk_q + 1'b1;
            state_d = ST_OLOAD;
          end
        end
      end
      ST_FIX: begin
        cnt_d   = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == idx_t'(CoeffCount - 1)) state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o.op       = DP_IDLE;
    cmd_o.outer    = 1'b0;
    cmd_o.load_idx = cnt_q;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    last_coeff_o   = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_OEVAL: cmd_o.op = DP_OEVAL;
      ST_IEVAL: cmd_o.op = DP_IEVAL;
      ST_IMUL:  cmd_o.op = DP_IMUL;
      ST_ISTEP: cmd_o.op = step_op(step_q);
      ST_OLOAD: cmd_o.op = DP_OLOAD;
      ST_OSTEP: begin
        cmd_o.op    = step_op(step_q);
        cmd_o.outer = 1'b1;
      end
      ST_FIX:   cmd_o.op = DP_FIX;
      ST_EMIT: begin
        out_valid_o  = 1'b1;
        last_coeff_o = (cnt_q == idx_t'(CoeffCount - 1));
        if (!out_stall_i) cmd_o.op = DP_SHIFT;
      end
      default: cmd_o.op = DP_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/toom4_poly_multiply_16.sv =====
// Top level of the 16-coefficient two-level Toom-4 polynomial multiplier.
// Depends on tpm_pkg, tpm_controller and tpm_datapath.
//
// Sixteen coefficient pairs are taken one word per cycle while in_stall_o is
// low. After the sixteenth the input stalls through one outer evaluation
// step, seven inner products (each an evaluation, seven passes through the
// single shared 32x32 multiplier and ten interpolation steps), four outer
// interpolation passes of a load and ten steps each, and one wrap-around fix-up.
// The sixteen product words then leave lowest degree first, one per cycle
// without output stall, and the input opens again after the last is taken.
module toom4_poly_multiply_16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] coeff_a_i,
  input  logic [31:0] coeff_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [26:0] product_coeff_o,
  output logic        last_coeff_o
);
  import tpm_pkg::*;

  cmd_t cmd;

  tpm_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .last_coeff_o (last_coeff_o),
    .cmd_o        (cmd)
  );

  tpm_datapath u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .coeff_a_i       (coeff_a_i),
    .coeff_b_i       (coeff_b_i),
    .product_coeff_o (product_coeff_o)
  );

endmodule

// ===== dv/tb_toom4_poly_multiply_16.sv =====
// Testbench for the 16-coefficient two-level Toom-4 polynomial multiplier.
// Self-checking against a behavioural product model; depends on tpm_pkg and the RTL.
module tb_toom4_poly_multiply_16;
  import tpm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] coeff_a_i = '0;
  logic [31:0] coeff_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [26:0] product_coeff_o;
  logic        last_coeff_o;

  typedef struct packed {
    logic [26:0] coeff;
    logic        last;
  } prod_word_t;

  word_t      poly_a [CoeffCount];
  word_t      poly_b [CoeffCount];
  int         pairs_loaded = 0;
  prod_word_t pending_coeffs[$];
  int         err_cnt = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  bit         rx_stall_on = 1'b1;

  localparam int unsigned WatchdogLimit = 4000;

  always #2 clk_i = ~clk_i;

  toom4_poly_multiply_16 dut (.*);

  // Evaluation at the seven points, slot order as in the datapath.
  function automatic void pts_eval(input word_t x[4], output word_t p[7]);
    word_t s, t;
    s = x[0] + x[2];
    t = x[1] + x[3];
    p[2] = s + t;
    p[3] = s - t;
    s = ((x[0] << 2) + x[2]) << 1;
    t = (x[1] << 2) + x[3];
    p[4] = s + t;
    p[5] = s - t;
    p[1] = (x[3] << 3) + (x[2] << 2) + (x[1] << 1) + x[0];
    p[6] = x[0];
    p[0] = x[3];
  endfunction

  function automatic logic [63:0] prod_33x21(word_t a, word_t b);
    word_t bv;
    bv = {{11{b[20]}}, b[20:0]};
    return ({32'd0, a} * {32'd0, bv}) & 64'h1_FFFF_FFFF;
  endfunction

  function automatic void toom_inner(input word_t a[4], input word_t b[4],
                                     output word_t c[4]);
    word_t pa[7], pb[7];
    logic [63:0] w[7], r1, r2, r3, r4, r5;
    logic [63:0] m33, m31, m30;
    m33 = 64'h1_FFFF_FFFF;
    m31 = 64'h7FFF_FFFF;
    m30 = 64'h3FFF_FFFF;
    pts_eval(a, pa);
    pts_eval(b, pb);
    for (int i = 0; i < 7; i++) w[i] = prod_33x21(pa[i], pb[i]);
    r5 = (w[5] - w[4]) & m33;
    r3 = ((w[3] - w[2]) & m33) >> 1;
    r4 = (w[4] - w[0]) & m33;
    r4 = ((r4 << 1) + r5 - (w[6] << 7)) & m33;
    r2 = (w[2] + r3) & m33;
    r1 = (w[1] + w[4] - (r2 << 6) - r2) & m33;
    r2 = (r2 - w[6] - w[0]) & m33;
    r1 = (r1 + r2 + (r2 << 2) + (r2 << 3) + (r2 << 5)) & m33;
    r4 = ((((r4 - (r2 << 3)) & m33) >> 3) * 64'h2AAA_AAAB) & m30;
    r5 = (((r5 + r1) >> 1) * 64'h6EEE_EEEF) & m31;
    r1 = ((((r1 + (r3 << 4)) & m33) >> 1) * 64'h38E3_8E39) & m31;
    r2 = (r2 - r4) & m30;
    r3 = (64'd0 - r3 - r1) & m30;
    r5 = (r1 - r5) >> 1;
    r1 = r1 - r5;
    c[0] = word_t'((w[6] - r2) & m30);
    c[1] = word_t'((r5 - r1) & m30);
    c[2] = word_t'((r4 - w[0]) & m30);
    c[3] = word_t'(r3 & m30);
  endfunction

  task automatic predict_product();
    word_t pa[7][4], pb[7][4], w[7][4];
    word_t blk[4], pt[7], ia[4], ib[4], iw[4], c[16];
    word_t r0, r1, r2, r3, r4, r5, r6, p0, p1, p2;
    p0 = 0; p1 = 0; p2 = 0;
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) blk[k] = poly_a[4*j+k];
      pts_eval(blk, pt);
      for (int k = 0; k < 7; k++) pa[k][j] = pt[k];
      for (int k = 0; k < 4; k++) blk[k] = poly_b[4*j+k];
      pts_eval(blk, pt);
      for (int k = 0; k < 7; k++) pb[k][j] = pt[k];
    end
    for (int k = 0; k < 7; k++) begin
      for (int j = 0; j < 4; j++) begin
        ia[j] = pa[k][j];
        ib[j] = pb[k][j];
      end
      toom_inner(ia, ib, iw);
      for (int j = 0; j < 4; j++) w[k][j] = iw[j];
    end
    for (int j = 0; j < 4; j++) begin
      r0 = w[0][j]; r2 = w[2][j]; r3 = w[3][j];
      r4 = w[4][j]; r5 = w[5][j]; r6 = w[6][j];
      r1 = (w[1][j] + r4) & 32'h3FFF_FFFF;
      r5 = (r5 - r4) & 32'h3FFF_FFFF;
      r3 = ((r3 - r2) >> 1) & 32'h3FFF_FFFF;
      r4 = (r4 - r0) & 32'h3FFF_FFFF;
      r4 = ((r4 << 1) + r5 - (r6 << 7)) & 32'h3FFF_FFFF;
      r2 = (r2 + r3) & 32'h3FFF_FFFF;
      r1 = (r1 - (r2 << 6) - r2) & 32'h3FFF_FFFF;
      r2 = (r2 - r6 - r0) & 32'h3FFF_FFFF;
      r1 = (r1 + r2 + (r2 << 2) + (r2 << 3) + (r2 << 5)) & 32'h3FFF_FFFF;
      r4 = ((((r4 - (r2 << 3)) & 32'h3FFF_FFFF) >> 3) * KInv3) & 32'h3FFF_FFFF;
      r5 = (((r5 + r1) >> 1) * KInv15O) & 32'h0FFF_FFFF;
      r1 = ((((r1 + (r3 << 4)) & 32'h3FFF_FFFF) >> 1) * KInv9O) & 32'h0FFF_FFFF;
      r2 = (r2 - r4) & 32'h07FF_FFFF;
      r3 = (32'd0 - r3 - r1) & 32'h07FF_FFFF;
      r5 = (r1 - r5) >> 1;
      r1 = r1 - r5;
      c[4*j+3] = r3;
      if (j == 0) begin
        c[0] = r6; c[1] = r5; c[2] = r4;
      end else begin
        c[4*j] = r6 + p2; c[4*j+1] = r5 + p1; c[4*j+2] = r4 + p0;
      end
      p0 = r0; p1 = r1; p2 = r2;
    end
    // top three terms wrap round negatively
    c[0] -= p2;
    c[1] -= p1;
    c[2] -= p0;
    for (int k = 0; k < CoeffCount; k++)
      pending_coeffs.push_back('{coeff: c[k][26:0], last: (k == CoeffCount - 1)});
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Drive one coefficient pair and wait for acceptance; gap precedes the word.
  // Returns at a falling edge with valid still high; the caller drops it.
  task automatic send_pair(word_t a, word_t b, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coeff_a_i  <= a;
    coeff_b_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    poly_a[pairs_loaded] = a;
    poly_b[pairs_loaded] = b;
    pairs_loaded++;
    if (pairs_loaded == CoeffCount) begin
      pairs_loaded = 0;
      predict_product();
    end
    @(negedge clk_i);
  endtask

  task automatic send_poly(word_t a[16], word_t b[16], bit gaps);
    for (int k = 0; k < CoeffCount; k++)
      send_pair(a[k], b[k], gaps ? rand_gap() : 0);
  endtask

  task automatic test_extremes();
    word_t a[16], b[16];
    for (int k = 0; k < CoeffCount; k++) begin
      a[k] = '1; b[k] = '1;
    end
    send_poly(a, b, 1'b0);
    for (int k = 0; k < CoeffCount; k++) begin
      a[k] = (k % 2) ? 32'h8000_0000 : 32'h0; b[k] = (k % 2) ? 32'h0 : 32'h0010_0000;
    end
    send_poly(a, b, 1'b0);
  endtask

  task automatic test_random_polys(int count);
    word_t a[16], b[16];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < CoeffCount; k++) begin
        case ($urandom_range(0, 5))
          0:       a[k] = '1;
          1:       a[k] = $urandom_range(0, 15);
          default: a[k] = $urandom;
        endcase
        case ($urandom_range(0, 5))
          0:       b[k] = 32'h001F_FFFF;
          1:       b[k] = 32'h0010_0000;
          default: b[k] = $urandom;
        endcase
      end
      send_poly(a, b, (n % 4) != 0);
    end
  endtask

  // Receiver stall pattern; held off now and then so words stream back to back.
  always @(negedge clk_i) begin
    if (rx_stall_on && stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!rx_stall_on || $urandom_range(0, 2) != 0) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if ($urandom_range(0, 19) == 0) begin
      // occasional long stall
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(8, 30);
    end else begin
      out_stall_i <= ($urandom_range(0, 1) == 1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_coeffs.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected word %h", product_coeff_o);
      end else begin
        prod_word_t e;
        e = pending_coeffs.pop_front();
        if (e.coeff !== product_coeff_o || e.last !== last_coeff_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp %h/%b got %h/%b", e.coeff, e.last,
                     product_coeff_o, last_coeff_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    rx_stall_on = 1'b0;
    test_random_polys(6);
    rx_stall_on = 1'b1;
    test_random_polys(18);
    in_valid_i <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
